// ===== hw/rtl/kda_pkg.sv =====
`timescale 1ns / 1ps

package kda_pkg;

   localparam logic [7:0] BTN_RESET = 8'h01;
   localparam logic [7:0] BTN_ENTER = 8'h02;
   localparam logic [7:0] BTN_UP    = 8'h04;
   localparam logic [7:0] BTN_DOWN  = 8'h08;

   localparam logic [6:0] CODE_UP      = 7'h75;
   localparam logic [6:0] CODE_DOWN    = 7'h64;
   localparam logic [6:0] CODE_KILL    = 7'h6B;
   localparam logic [6:0] CODE_C       = 7'h63;
   localparam logic [6:0] CODE_S       = 7'h73;
   localparam logic [6:0] CODE_P       = 7'h70;
   localparam logic [6:0] CODE_T       = 7'h74;
   localparam logic [6:0] CODE_RELEASE = 7'h72;
   localparam logic [6:0] CODE_FUNC    = 7'h66;

   localparam logic [2:0] REG_SCAN_SLOTS     = 3'd0;
   localparam logic [2:0] REG_DEBOUNCE_SCANS = 3'd1;
   localparam logic [2:0] REG_RAMP_START     = 3'd2;
   localparam logic [2:0] REG_RAMP_END       = 3'd3;
   localparam logic [2:0] REG_RAMP_STEP      = 3'd4;

   localparam logic [3:0] MAX_SLOTS = 4'd8;

   typedef struct packed {
      logic [3:0] scan_slots;
      logic [7:0] debounce_scans;
      logic [7:0] ramp_start;
      logic [7:0] ramp_end;
      logic [7:0] ramp_step;
   } kda_cfg_type;

   typedef struct packed {
      logic       accept;
      logic       code_valid;
      logic [6:0] code;
      logic [7:0] accepted;
   } kda_scan_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] code;
   } kda_lookup_type;

   function automatic kda_lookup_type kda_lookup(input logic [7:0] pattern);
      kda_lookup_type r;
      r.hit  = 1'b1;
      r.code = '0;
      case (pattern)
         BTN_UP:                      r.code = CODE_UP;
         BTN_DOWN:                    r.code = CODE_DOWN;
         BTN_RESET:                   r.code = CODE_KILL;
         BTN_UP | BTN_RESET:          r.code = CODE_C;
         BTN_DOWN | BTN_RESET:        r.code = CODE_S;
         BTN_UP | BTN_DOWN | BTN_RESET: r.code = CODE_P;
         BTN_UP | BTN_ENTER:          r.code = CODE_T;
         default:                     r.hit  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/kda_req_if.sv =====
`timescale 1ns / 1ps

interface kda_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] strobe_mask;
   logic       pin_pressed;

   modport source (output valid, output strobe_mask, output pin_pressed, input ready);
   modport sink   (input valid, input strobe_mask, input pin_pressed, output ready);
endinterface

// ===== hw/rtl/kda_rsp_if.sv =====
`timescale 1ns / 1ps

interface kda_rsp_if;
   logic       valid;
   logic       ready;
   logic       key_valid;
   logic [6:0] key_code;
   logic       restart_timeout;

   modport source (output valid, output key_valid, output key_code,
                   output restart_timeout, input ready);
   modport sink   (input valid, input key_valid, input key_code,
                   input restart_timeout, output ready);
endinterface

// ===== hw/rtl/kda_scan.sv =====
`timescale 1ns / 1ps

module kda_scan
   import kda_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic [7:0]   strobe_mask,
   input  logic         pin_pressed,
   input  kda_cfg_type  cfg,
   input  logic         function_fired,
   output kda_scan_type scan
);

   logic [7:0] accum_ff, accum_in;
   logic [2:0] slot_ff, slot_in;
   logic [7:0] stable_ff, stable_in;
   logic [7:0] debounce_ff, debounce_in;
   logic [7:0] accepted_ff, accepted_in;

   logic [7:0]     accum_or;
   logic [3:0]     limit;
   logic [3:0]     slot_next;
   logic           close;
   logic [7:0]     debounce_load;
   kda_lookup_type lookup;

   always_comb begin
      accum_or      = pin_pressed ? (accum_ff | strobe_mask) : accum_ff;
      limit         = (cfg.scan_slots > MAX_SLOTS) ? MAX_SLOTS : cfg.scan_slots;
      slot_next     = {1'b0, slot_ff} + 4'd1;
      close         = (slot_next >= limit);
      accum_in      = accum_or;
      slot_in       = slot_next[2:0];
      stable_in     = stable_ff;
      debounce_in   = debounce_ff;
      accepted_in   = accepted_ff;
      debounce_load = debounce_ff;
      lookup        = kda_lookup(accum_or);
      scan.accept     = 1'b0;
      scan.code_valid = 1'b0;
      scan.code       = '0;
      if (close) begin
         slot_in  = '0;
         accum_in = '0;
         if (accum_or != stable_ff) begin
            debounce_load = cfg.debounce_scans;
            stable_in     = accum_or;
         end
         debounce_in = (debounce_load != 8'd0) ? (debounce_load - 8'd1) : 8'd0;
         lookup      = kda_lookup(stable_in);
         if ((accepted_ff != stable_in) && (debounce_in == 8'd0)) begin
            scan.accept     = 1'b1;
            scan.code_valid = lookup.hit;
            scan.code       = lookup.code;
            if ((accepted_ff == BTN_ENTER) && (stable_in == 8'd0) && !function_fired) begin
               scan.code_valid = 1'b1;
               scan.code       = CODE_RELEASE;
            end
            accepted_in = stable_in;
         end
      end
      scan.accepted = accepted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         slot_ff     <= '0;
         stable_ff   <= '0;
         debounce_ff <= '0;
         accepted_ff <= '0;
      end else if (advance) begin
         accum_ff    <= accum_in;
         slot_ff     <= slot_in;
         stable_ff   <= stable_in;
         debounce_ff <= debounce_in;
         accepted_ff <= accepted_in;
      end
   end

endmodule

// ===== hw/rtl/kda_repeat.sv =====
`timescale 1ns / 1ps

module kda_repeat
   import kda_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  kda_cfg_type  cfg,
   input  kda_scan_type scan,
   output logic         function_fired,
   output logic         key_valid,
   output logic [6:0]   key_code,
   output logic         restart_timeout
);

   logic [7:0] count_ff, count_in;
   logic [7:0] interval_ff, interval_in;
   logic       fired_ff, fired_in;

   logic [7:0]  count0;
   logic [7:0]  interval0;
   logic [7:0]  interval1;
   logic [11:0] interval_x11;
   logic [11:0] start_x10;

   always_comb begin
      count0      = scan.accept ? 8'd0 : count_ff;
      interval0   = scan.accept ? cfg.ramp_start : interval_ff;
      fired_in    = (scan.accept && (scan.accepted == 8'd0)) ? 1'b0 : fired_ff;
      count_in    = count0;
      interval_in = interval0;
      interval1   = interval0;
      if (interval0 > cfg.ramp_end) begin
         interval1 = (interval0 > cfg.ramp_step) ? (interval0 - cfg.ramp_step) : 8'd0;
      end
      interval_x11    = {4'd0, interval1} * 12'd11;
      start_x10       = {4'd0, cfg.ramp_start} * 12'd10;
      key_valid       = scan.code_valid;
      key_code        = scan.code;
      restart_timeout = scan.accept;
      if (scan.accepted != 8'd0) begin
         if (count0 < interval0) begin
            count_in = count0 + 8'd1;
         end else begin
            count_in        = '0;
            interval_in     = interval1;
            restart_timeout = 1'b1;
            case (scan.accepted)
               BTN_DOWN: begin
                  key_valid = 1'b1;
                  key_code  = CODE_DOWN;
               end
               BTN_UP: begin
                  key_valid = 1'b1;
                  key_code  = CODE_UP;
               end
               BTN_ENTER: begin
                  if (interval_x11 <= start_x10) begin
                     key_valid   = 1'b1;
                     key_code    = CODE_FUNC;
                     interval_in = cfg.ramp_start;
                     fired_in    = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      if (!key_valid) begin
         key_code = '0;
      end
   end

   assign function_fired = fired_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         interval_ff <= '0;
         fired_ff    <= 1'b0;
      end else if (advance) begin
         count_ff    <= count_in;
         interval_ff <= interval_in;
         fired_ff    <= fired_in;
      end
   end

endmodule

// ===== hw/rtl/keypad_debounce_autorepeat_core.sv =====
`timescale 1ns / 1ps

// Keypad debounce and auto-repeat core. Each req transaction is one scan tick
// (strobe mask and pin level); the core takes one tick per clock while the rsp
// channel is not stalled. A tick is held in an input register, and the scan,
// debounce and repeat state is then updated in a single pass that fills the
// result register. Ticks that raise neither a key code nor a timeout restart
// give no rsp transaction. A stalled rsp channel holds the pipeline once the
// result register is full. Write the csr registers only while idle: index 0
// scan_slots, 1 debounce_scans, 2 ramp_start, 3 ramp_end, 4 ramp_step.
module keypad_debounce_autorepeat_core
   import kda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kda_req_if.sink    req_chan,
   kda_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   kda_cfg_type cfg_ff;

   logic       in_valid_ff;
   logic [7:0] in_strobe_ff;
   logic       in_pin_ff;

   logic       out_valid_ff;
   logic       out_key_valid_ff;
   logic [6:0] out_key_code_ff;
   logic       out_restart_ff;

   logic         advance;
   logic         function_fired;
   logic         key_valid;
   logic [6:0]   key_code;
   logic         restart_timeout;
   kda_scan_type scan;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_slots     <= 4'd4;
         cfg_ff.debounce_scans <= 8'd3;
         cfg_ff.ramp_start     <= 8'd100;
         cfg_ff.ramp_end       <= 8'd20;
         cfg_ff.ramp_step      <= 8'd10;
      end else if (csr_we) begin
         case (csr_index)
            REG_SCAN_SLOTS:     cfg_ff.scan_slots     <= csr_wdata[3:0];
            REG_DEBOUNCE_SCANS: cfg_ff.debounce_scans <= csr_wdata;
            REG_RAMP_START:     cfg_ff.ramp_start     <= csr_wdata;
            REG_RAMP_END:       cfg_ff.ramp_end       <= csr_wdata;
            REG_RAMP_STEP:      cfg_ff.ramp_step      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_strobe_ff <= req_chan.strobe_mask;
         in_pin_ff    <= req_chan.pin_pressed;
      end
   end

   kda_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .strobe_mask    (in_strobe_ff),
      .pin_pressed    (in_pin_ff),
      .cfg            (cfg_ff),
      .function_fired (function_fired),
      .scan           (scan)
   );

   kda_repeat u_repeat (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cfg             (cfg_ff),
      .scan            (scan),
      .function_fired  (function_fired),
      .key_valid       (key_valid),
      .key_code        (key_code),
      .restart_timeout (restart_timeout)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= key_valid || restart_timeout;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_key_valid_ff <= key_valid;
         out_key_code_ff  <= key_code;
         out_restart_ff   <= restart_timeout;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.key_valid       = out_key_valid_ff;
   assign rsp_chan.key_code        = out_key_code_ff;
   assign rsp_chan.restart_timeout = out_restart_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import kda_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   typedef struct packed {
      logic       key_valid;
      logic [6:0] key_code;
      logic       restart_timeout;
   } key_event_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   kda_req_if req_chan();
   kda_rsp_if rsp_chan();

   keypad_debounce_autorepeat_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // keypad state as the block should hold it
   kda_cfg_type kcfg = '{scan_slots: 4'd4, debounce_scans: 8'd3, ramp_start: 8'd100,
                         ramp_end: 8'd20, ramp_step: 8'd10};
   logic [7:0] scan_acc   = '0;
   logic [2:0] slot_cnt   = '0;
   logic [7:0] stable_pat = '0;
   logic [7:0] deb_left   = '0;
   logic [7:0] acc_pat    = '0;
   logic [7:0] rpt_cnt    = '0;
   logic [7:0] rpt_ivl    = '0;
   logic       func_fired = 1'b0;

   key_event_type pending_events[$];
   key_event_type got_event;
   key_event_type want_event;
   int unsigned mismatches     = 0;
   int unsigned ticks_sent     = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned rsp_hold_left  = 0;
   int unsigned quiet_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void predict_key_event(input logic [7:0] strobe, input logic pin);
      key_event_type ev;
      logic [6:0]    code;
      int unsigned   limit;
      int unsigned   nxt;
      ev = '0;
      if (pin)
         scan_acc = scan_acc | strobe;
      limit = (kcfg.scan_slots > MAX_SLOTS) ? MAX_SLOTS : kcfg.scan_slots;
      nxt = slot_cnt + 1;
      if (nxt >= limit) begin
         slot_cnt = '0;
         if (scan_acc != stable_pat) begin
            deb_left   = kcfg.debounce_scans;
            stable_pat = scan_acc;
         end
         scan_acc = '0;
         if (deb_left != 0)
            deb_left--;
         if (acc_pat != stable_pat && deb_left == 0) begin
            case (stable_pat)
               BTN_UP:                        code = CODE_UP;
               BTN_DOWN:                      code = CODE_DOWN;
               BTN_RESET:                     code = CODE_KILL;
               BTN_UP | BTN_RESET:            code = CODE_C;
               BTN_DOWN | BTN_RESET:          code = CODE_S;
               BTN_UP | BTN_DOWN | BTN_RESET: code = CODE_P;
               BTN_UP | BTN_ENTER:            code = CODE_T;
               default:                       code = '0;
            endcase
            ev.key_valid = (code != '0);
            ev.key_code  = code;
            // short enter press
            if (acc_pat == BTN_ENTER && stable_pat == '0 && !func_fired) begin
               ev.key_valid = 1'b1;
               ev.key_code  = CODE_RELEASE;
            end
            if (stable_pat == '0)
               func_fired = 1'b0;
            ev.restart_timeout = 1'b1;
            acc_pat = stable_pat;
            rpt_cnt = '0;
            rpt_ivl = kcfg.ramp_start;
         end
      end else begin
         slot_cnt = nxt[2:0];
      end
      if (acc_pat != '0) begin
         if (rpt_cnt < rpt_ivl) begin
            rpt_cnt++;
         end else begin
            rpt_cnt = '0;
            if (rpt_ivl > kcfg.ramp_end)
               rpt_ivl = (rpt_ivl > kcfg.ramp_step) ? rpt_ivl - kcfg.ramp_step : '0;
            case (acc_pat)
               BTN_DOWN: begin
                  ev.key_valid = 1'b1;
                  ev.key_code  = CODE_DOWN;
               end
               BTN_UP: begin
                  ev.key_valid = 1'b1;
                  ev.key_code  = CODE_UP;
               end
               BTN_ENTER: begin
                  if (int'(rpt_ivl) <= (int'(kcfg.ramp_start) * 10) / 11) begin
                     ev.key_valid = 1'b1;
                     ev.key_code  = CODE_FUNC;
                     rpt_ivl      = kcfg.ramp_start;
                     func_fired   = 1'b1;
                  end
               end
               default: ;
            endcase
            ev.restart_timeout = 1'b1;
         end
      end
      if (ev.key_valid || ev.restart_timeout)
         pending_events.push_back(ev);
   endfunction

   task automatic send_tick(input logic [7:0] strobe, input logic pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.strobe_mask <= strobe;
      req_chan.pin_pressed <= pin;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_key_event(strobe, pin);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_events.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_SCAN_SLOTS:     kcfg.scan_slots     = val[3:0];
         REG_DEBOUNCE_SCANS: kcfg.debounce_scans = val;
         REG_RAMP_START:     kcfg.ramp_start     = val;
         REG_RAMP_END:       kcfg.ramp_end       = val;
         REG_RAMP_STEP:      kcfg.ramp_step      = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setup(input logic [3:0] slots, input logic [7:0] deb,
                              input logic [7:0] start, input logic [7:0] ramp_floor,
                              input logic [7:0] ramp_dec);
      wait_idle();
      write_reg(REG_SCAN_SLOTS, {4'h0, slots});
      write_reg(REG_DEBOUNCE_SCANS, deb);
      write_reg(REG_RAMP_START, start);
      write_reg(REG_RAMP_END, ramp_floor);
      write_reg(REG_RAMP_STEP, ramp_dec);
      csr_we <= 1'b0;
   endtask

   // strobe the columns of each slot in turn, pressing the pattern's keys
   task automatic hold_keys(input logic [7:0] pattern, input int unsigned scans,
                            input int unsigned glitch_pct);
      int unsigned span;
      int unsigned col;
      int          j;
      logic [7:0]  cols;
      logic [7:0]  hit;
      logic        pin;
      span = (kcfg.scan_slots == 0) ? 1 :
             (kcfg.scan_slots > MAX_SLOTS) ? MAX_SLOTS : kcfg.scan_slots;
      repeat (scans * span) begin
         col  = slot_cnt % span;
         cols = '0;
         for (j = 0; j < 8; j++)
            if (j % span == col)
               cols[j] = 1'b1;
         hit = pattern & cols;
         pin = (hit != '0);
         if ($urandom_range(99) < glitch_pct)
            pin = !pin;
         send_tick((hit != '0) ? hit : cols, pin);
      end
   endtask

   function automatic logic [7:0] pick_pattern();
      case ($urandom_range(11))
         0:       return 8'h00;
         1:       return BTN_UP;
         2:       return BTN_DOWN;
         3, 9:    return BTN_ENTER;
         4:       return BTN_RESET;
         5:       return BTN_UP | BTN_RESET;
         6:       return BTN_DOWN | BTN_RESET;
         7:       return BTN_UP | BTN_DOWN | BTN_RESET;
         8:       return BTN_UP | BTN_ENTER;
         10:      return 8'h00;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic run_sequences(input int unsigned n, input int unsigned max_scans,
                                input int unsigned glitch_pct);
      int unsigned stop_at;
      stop_at = ticks_sent + n;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(99) < 12)
            repeat ($urandom_range(6, 1))
               send_tick(8'($urandom_range(255)), 1'($urandom_range(1)));
         else
            hold_keys(pick_pattern(), $urandom_range(max_scans, 1), glitch_pct);
      end
   endtask

   task automatic test_directed_codes();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_setup(4'd1, 8'd0, 8'd2, 8'd0, 8'd255);
      repeat (4) send_tick(BTN_UP, 1'b1);
      repeat (4) send_tick(BTN_DOWN, 1'b1);
      send_tick(BTN_RESET, 1'b1);
      send_tick(BTN_UP | BTN_RESET, 1'b1);
      send_tick(BTN_DOWN | BTN_RESET, 1'b1);
      send_tick(BTN_UP | BTN_DOWN | BTN_RESET, 1'b1);
      send_tick(BTN_UP | BTN_ENTER, 1'b1);
      send_tick(BTN_ENTER, 1'b1);
      send_tick(8'h00, 1'b0);
      repeat (4) send_tick(BTN_ENTER, 1'b1);
      send_tick(8'h00, 1'b1);
      send_tick(8'hFF, 1'b1);
      send_tick(8'hFF, 1'b0);
      send_tick(8'h80, 1'b1);
      send_tick(8'h00, 1'b0);
   endtask

   task automatic test_default_timing();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_setup(4'd4, 8'd3, 8'd100, 8'd20, 8'd10);
      run_sequences(500, 40, 2);
   endtask

   task automatic test_fast_ramp();
      send_idle_pct  = 0;
      recv_stall_pct = 58;
      apply_setup(4'd2, 8'd1, 8'd12, 8'd3, 8'd4);
      run_sequences(400, 30, 3);
   endtask

   task automatic test_flat_ramp();
      send_idle_pct  = 58;
      recv_stall_pct = 0;
      apply_setup(4'd3, 8'd2, 8'd30, 8'd255, 8'd7);
      run_sequences(300, 25, 3);
   endtask

   task automatic test_long_debounce();
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      apply_setup(4'd0, 8'd255, 8'd1, 8'd0, 8'd0);
      hold_keys(BTN_UP, 262, 0);
   endtask

   task automatic test_wide_scan();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_setup(4'd15, 8'd0, 8'd255, 8'd0, 8'd255);
      hold_keys(BTN_ENTER, 34, 0);
      hold_keys(8'h00, 2, 0);
      hold_keys(BTN_ENTER, 3, 0);
      hold_keys(8'h00, 2, 0);
   endtask

   task automatic test_output_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_setup(4'd1, 8'd0, 8'd1, 8'd0, 8'd1);
      rsp_hold_left = 150;
      hold_keys(BTN_DOWN, 60, 0);
      wait_idle();
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.strobe_mask = '0;
      req_chan.pin_pressed = 1'b0;
      csr_we               = 1'b0;
      csr_index            = REG_SCAN_SLOTS;
      csr_wdata            = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_codes();
      test_default_timing();
      test_fast_ramp();
      test_flat_ramp();
      test_long_debounce();
      test_wide_scan();
      test_output_stall();
      wait_idle();
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("** keypad_debounce_autorepeat_core: PASSED **");
      else
         $display("** keypad_debounce_autorepeat_core: FAILED **");
      $finish;
   end

   // result sink: random stalls, or a counted hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_event = {rsp_chan.key_valid, rsp_chan.key_code, rsp_chan.restart_timeout};
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, got valid=%0b code=%h restart=%0b",
                     $time, got_event.key_valid, got_event.key_code, got_event.restart_timeout);
            mismatches++;
         end else begin
            want_event = pending_events.pop_front();
            if (got_event.key_valid !== want_event.key_valid) begin
               $display("%0t: key_valid expected %0b got %0b",
                        $time, want_event.key_valid, got_event.key_valid);
               mismatches++;
            end
            if (got_event.key_code !== want_event.key_code) begin
               $display("%0t: key_code expected %h got %h",
                        $time, want_event.key_code, got_event.key_code);
               mismatches++;
            end
            if (got_event.restart_timeout !== want_event.restart_timeout) begin
               $display("%0t: restart_timeout expected %0b got %0b",
                        $time, want_event.restart_timeout, got_event.restart_timeout);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_events.size());
         $display("** keypad_debounce_autorepeat_core: FAILED **");
         $finish;
      end
   end

endmodule

// ===== files.f =====
hw/rtl/kda_pkg.sv
hw/rtl/kda_req_if.sv
hw/rtl/kda_rsp_if.sv
hw/rtl/kda_scan.sv
hw/rtl/kda_repeat.sv
hw/rtl/keypad_debounce_autorepeat_core.sv
tb/sv/tb_top.sv
